>>> rtl/core/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the Hamming SEC codec
// Widths, register indexes and constant helper functions that map code
// positions to data bits and to check coverage.
// ----------------------------------------------------------------------------
package hsc_pkg;

   // Largest code length the syndrome can address.
   localparam int MAX_POS         = 63;
   localparam int SYN_W           = 6;
   localparam int LEN_W           = 6;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 6;

   localparam int DEFAULT_DATA_BITS = 32;
   localparam int DEFAULT_CODE_BITS = 38;

   localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = LEN_W'(32);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PARITY_MODE = 1'b0,
      CSR_DATA_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   // True when q is a power of two (check position).
   function automatic bit is_pow2(input int q);
      return (q & (q - 1)) == 0;
   endfunction

   // Code position (from 1) that carries data bit d.
   function automatic int data_pos(input int d);
      int pos;
      int placed;
      pos    = 0;
      placed = 0;
      while (placed <= d) begin
         pos++;
         if (!is_pow2(pos)) placed++;
      end
      return pos;
   endfunction

   // Positions covered by check bit i; bit q-1 stands for position q.
   function automatic logic [MAX_POS-1:0] cover_mask(input int i);
      logic [MAX_POS-1:0] m;
      m = '0;
      for (int q = 1; q <= MAX_POS; q++) begin
         m[q-1] = ((q >> i) & 1) != 0;
      end
      return m;
   endfunction

endpackage

>>> rtl/core/hamming_sec_codec.sv
// ----------------------------------------------------------------------------
// hamming_sec_codec: Hamming single-error-correcting encoder and decoder
// Encodes data words into code words or decodes and corrects code words,
// with a configurable data length and even or odd check parity.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one beat per word: req_operation selects encode
//   or decode and req_word_in holds the data or code bits. A beat is taken at
//   a rising edge with req_valid high and req_stall low. The rsp_ channel
//   returns one beat per request, in order, with the code word or corrected
//   data, the syndrome and the corrected and uncorrectable flags.
//   The request lands in an input register, the parity trees, syndrome
//   compare and bit flip run in one combinational pass, and the result
//   lands in the output register. Throughput is one beat per cycle while
//   the receiver does not stall, as the single-pass parity logic allows.
//   When the receiver stalls, the output register holds its beat and the
//   input register keeps accepting until it is also full, at which point
//   req_stall rises. The csr_ channel writes parity_mode and data_length; it
//   is always ready and must only be used while the codec holds no beats.
//   Synchronous reset empties both registers and restores even parity with
//   a data length of 32.
// ----------------------------------------------------------------------------
module hamming_sec_codec
   import hsc_pkg::*;
#(
   parameter int DATA_BITS = DEFAULT_DATA_BITS,
   parameter int CODE_BITS = DEFAULT_CODE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [CODE_BITS-1:0]  req_word_in,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_BITS-1:0]  rsp_word_out,
   output logic [SYN_W-1:0]      rsp_syndrome,
   output logic                  rsp_corrected,
   output logic                  rsp_uncorrectable,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic             parity_mode_ff, parity_mode_in;
   logic [LEN_W-1:0] data_length_ff, data_length_in;

   assign csr_ready = 1'b1;

   always_comb begin
      parity_mode_in = parity_mode_ff;
      data_length_in = data_length_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PARITY_MODE: parity_mode_in = csr_wdata[0];
            CSR_DATA_LENGTH: data_length_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_mode_ff <= 1'b0;
         data_length_ff <= DATA_LENGTH_RESET;
      end else begin
         parity_mode_ff <= parity_mode_in;
         data_length_ff <= data_length_in;
      end
   end

   // ------------------------------------------------------------------
   // Two-register pipeline control. The output register loads when it is
   // empty or its beat leaves; the input register loads when it is empty or
   // its beat moves on.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s2_load, s1_load;

   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (s1_load) s1_valid_in = req_valid;
      if (s2_load) s2_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Input payload register
   logic                 s1_op_ff;
   logic [CODE_BITS-1:0] s1_word_ff;

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_op_ff   <= req_operation;
         s1_word_ff <= req_word_in;
      end
   end

   // ------------------------------------------------------------------
   // Active lengths: k data bits, clamped to 1..DATA_BITS, and the code
   // length k + r where r is the smallest check count with 2^r >= k+r+1.
   // ------------------------------------------------------------------
   logic [LEN_W-1:0] k_act;
   logic [LEN_W-1:0] code_len;

   always_comb begin
      k_act = data_length_ff;
      if (k_act == '0) k_act = LEN_W'(1);
      if (k_act > LEN_W'(DATA_BITS)) k_act = LEN_W'(DATA_BITS);
   end

   always_comb begin
      code_len = '0;
      for (int r = SYN_W; r >= 1; r--) begin
         if ((SYN_W + 2)'(1 << r) >= (SYN_W + 2)'(k_act) + (SYN_W + 2)'(r + 1)) begin
            code_len = k_act + LEN_W'(r);
         end
      end
   end

   // Position mask: bit q-1 is set for every position q within the code.
   logic [CODE_BITS-1:0] pos_mask;

   always_comb begin
      for (int q = 1; q <= CODE_BITS; q++) begin
         pos_mask[q-1] = (LEN_W + 1)'(q) <= (LEN_W + 1)'(code_len);
      end
   end

   // ------------------------------------------------------------------
   // Encode: scatter data bits onto non-power-of-two positions, then fill
   // each check position with the parity of the data it covers.
   // ------------------------------------------------------------------
   logic [CODE_BITS-1:0] enc_data;
   logic [CODE_BITS-1:0] enc_word;

   always_comb begin
      enc_data = '0;
      for (int d = 0; d < DATA_BITS; d++) begin
         if (data_pos(d) <= CODE_BITS) begin
            enc_data[data_pos(d)-1] = s1_word_ff[d] && (LEN_W'(d) < k_act);
         end
      end
   end

   always_comb begin
      enc_word = enc_data;
      for (int i = 0; i < SYN_W; i++) begin
         if ((1 << i) <= CODE_BITS) begin
            enc_word[(1 << i)-1] = pos_mask[(1 << i)-1] &&
               (parity_mode_ff ^ (^(enc_data & CODE_BITS'(cover_mask(i)))));
         end
      end
   end

   // ------------------------------------------------------------------
   // Decode: each syndrome bit is the failing check at position 2^i, the
   // addressed bit flips when it lies within the code, then checks strip.
   // ------------------------------------------------------------------
   logic [CODE_BITS-1:0] dec_word;
   logic [SYN_W-1:0]     dec_syn;
   logic                 dec_corr;
   logic                 dec_unc;
   logic [CODE_BITS-1:0] dec_fixed;
   logic [CODE_BITS-1:0] dec_data;

   assign dec_word = s1_word_ff & pos_mask;

   always_comb begin
      dec_syn = '0;
      for (int i = 0; i < SYN_W; i++) begin
         if ((1 << i) <= CODE_BITS) begin
            dec_syn[i] = pos_mask[(1 << i)-1] &&
               (parity_mode_ff ^ (^(dec_word & CODE_BITS'(cover_mask(i)))));
         end
      end
   end

   // A syndrome beyond the code length cannot address a bit.
   assign dec_unc  = dec_syn > code_len;
   assign dec_corr = (dec_syn != '0) && !dec_unc;

   always_comb begin
      for (int q = 1; q <= CODE_BITS; q++) begin
         dec_fixed[q-1] = dec_word[q-1] ^ (dec_corr && (dec_syn == SYN_W'(q)));
      end
   end

   always_comb begin
      dec_data = '0;
      for (int d = 0; d < DATA_BITS; d++) begin
         if (data_pos(d) <= CODE_BITS && d < CODE_BITS) begin
            dec_data[d] = dec_fixed[data_pos(d)-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic [CODE_BITS-1:0] word_out_ff, word_out_in;
   logic [SYN_W-1:0]     syndrome_ff, syndrome_in;
   logic                 corrected_ff, corrected_in;
   logic                 uncorr_ff, uncorr_in;

   always_comb begin
      case (op_type'(s1_op_ff))
         OP_DECODE: begin
            word_out_in  = dec_data;
            syndrome_in  = dec_syn;
            corrected_in = dec_corr;
            uncorr_in    = dec_unc;
         end
         default: begin
            word_out_in  = enc_word;
            syndrome_in  = '0;
            corrected_in = 1'b0;
            uncorr_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         word_out_ff  <= word_out_in;
         syndrome_ff  <= syndrome_in;
         corrected_ff <= corrected_in;
         uncorr_ff    <= uncorr_in;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_word_out      = word_out_ff;
   assign rsp_syndrome      = syndrome_ff;
   assign rsp_corrected     = corrected_ff;
   assign rsp_uncorrectable = uncorr_ff;

endmodule

>>> rtl/core/hsc_checker.sv
// ----------------------------------------------------------------------------
// hsc_checker: port-level checks for the Hamming SEC codec
// Watches the response channel and the reset behavior of the top level.
// ----------------------------------------------------------------------------
module hsc_checker
   import hsc_pkg::*;
#(
   parameter int CODE_BITS = DEFAULT_CODE_BITS
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [CODE_BITS-1:0] rsp_word_out,
   input logic [SYN_W-1:0]     rsp_syndrome,
   input logic                 rsp_corrected,
   input logic                 rsp_uncorrectable
);

   // A stalled beat stays valid.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled beat keeps its word.
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_word_out))
      else $error("response word changed while stalled");

   // A corrected beat carries a nonzero syndrome and is not uncorrectable.
   a_corr_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_corrected |-> rsp_syndrome != '0 && !rsp_uncorrectable)
      else $error("corrected beat with bad flags");

   // An uncorrectable beat carries a nonzero syndrome and no correction.
   a_unc_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_uncorrectable |-> rsp_syndrome != '0 && !rsp_corrected)
      else $error("uncorrectable beat with bad flags");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind hamming_sec_codec hsc_checker #(.CODE_BITS(CODE_BITS)) u_hsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_word_out      (rsp_word_out),
   .rsp_syndrome      (rsp_syndrome),
   .rsp_corrected     (rsp_corrected),
   .rsp_uncorrectable (rsp_uncorrectable)
);
